/* sv/rvab_pkg.sv */
// ---------------------------------------------------------------------------
// rvab_pkg
// Opcode codes and the result word layout shared by the ALU/branch block.
// ---------------------------------------------------------------------------
package rvab_pkg;

   localparam int unsigned OpW   = 5;
   localparam int unsigned XlenW = 32;

   // operation codes
   localparam logic [OpW-1:0] OP_LUI   = 5'd0;
   localparam logic [OpW-1:0] OP_AUIPC = 5'd1;
   localparam logic [OpW-1:0] OP_JAL   = 5'd2;
   localparam logic [OpW-1:0] OP_JALR  = 5'd3;
   localparam logic [OpW-1:0] OP_BEQ   = 5'd4;
   localparam logic [OpW-1:0] OP_BNE   = 5'd5;
   localparam logic [OpW-1:0] OP_BLT   = 5'd6;
   localparam logic [OpW-1:0] OP_BGE   = 5'd7;
   localparam logic [OpW-1:0] OP_BLTU  = 5'd8;
   localparam logic [OpW-1:0] OP_BGEU  = 5'd9;
   localparam logic [OpW-1:0] OP_ADDI  = 5'd10;
   localparam logic [OpW-1:0] OP_SLTI  = 5'd11;
   localparam logic [OpW-1:0] OP_SLTIU = 5'd12;
   localparam logic [OpW-1:0] OP_XORI  = 5'd13;
   localparam logic [OpW-1:0] OP_ORI   = 5'd14;
   localparam logic [OpW-1:0] OP_ANDI  = 5'd15;
   localparam logic [OpW-1:0] OP_SLLI  = 5'd16;
   localparam logic [OpW-1:0] OP_SRLI  = 5'd17;
   localparam logic [OpW-1:0] OP_SRAI  = 5'd18;
   localparam logic [OpW-1:0] OP_ADD   = 5'd19;
   localparam logic [OpW-1:0] OP_SUB   = 5'd20;
   localparam logic [OpW-1:0] OP_SLL   = 5'd21;
   localparam logic [OpW-1:0] OP_SLT   = 5'd22;
   localparam logic [OpW-1:0] OP_SLTU  = 5'd23;
   localparam logic [OpW-1:0] OP_XOR   = 5'd24;
   localparam logic [OpW-1:0] OP_SRL   = 5'd25;
   localparam logic [OpW-1:0] OP_SRA   = 5'd26;
   localparam logic [OpW-1:0] OP_OR    = 5'd27;
   localparam logic [OpW-1:0] OP_AND   = 5'd28;

   // link and fall-through offset
   localparam logic [XlenW-1:0] InstrBytes = 32'd4;

   // computed result word, without the tag
   typedef struct packed {
      logic [XlenW-1:0] result_value;
      logic             control_op;
      logic             taken_flag;
      logic [XlenW-1:0] resolved_addr;
      logic             mispredicted;
   } rsp_type;

endpackage

/* sv/rv32i_alu_branch_resolve.sv */
// ---------------------------------------------------------------------------
// rv32i_alu_branch_resolve
// RV32I integer ALU with branch and jump resolution.
//
// Each request word carries an opcode, two register operands, the immediate,
// the instruction address, the predicted next address and a reorder buffer
// tag; each request yields exactly one response word with the destination
// value, the control flags, the resolved next address and the tag. The unit
// takes one word per clock while req_ready is high. An accepted request waits
// in the operand register; the ALU, comparator and target adders then settle
// into the response register once it is empty or drains, and the response
// word is offered from there. The operand register keeps filling while a
// response waits; once both registers are full, req_ready follows rsp_ready.
// The tag width follows TAG_ENTRIES and the tag is passed through untouched.
// ---------------------------------------------------------------------------
module rv32i_alu_branch_resolve
   import rvab_pkg::*;
#(
   parameter int unsigned TAG_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [OpW-1:0]                 req_opcode,
   input  logic [XlenW-1:0]               req_operand_a,
   input  logic [XlenW-1:0]               req_operand_b,
   input  logic signed [XlenW-1:0]        req_immediate,
   input  logic [XlenW-1:0]               req_instr_addr,
   input  logic [XlenW-1:0]               req_predicted_addr,
   input  logic [$clog2(TAG_ENTRIES)-1:0] req_entry_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [XlenW-1:0]               rsp_result_value,
   output logic                           rsp_control_op,
   output logic                           rsp_taken_flag,
   output logic [XlenW-1:0]               rsp_resolved_addr,
   output logic                           rsp_mispredicted,
   output logic [$clog2(TAG_ENTRIES)-1:0] rsp_out_tag
);

   localparam int unsigned TagW = $clog2(TAG_ENTRIES);

   // operand stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [OpW-1:0]       op_ff;
   logic [XlenW-1:0]     a_ff, b_ff, imm_ff, pc_ff, pred_ff;
   logic [TagW-1:0]      s1_tag_ff;

   // response stage
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [TagW-1:0]      rsp_tag_ff;

   logic                 s2_open, s1_open, s1_fire;

   // datapath terms
   logic [XlenW-1:0]     sum_a_imm, sum_pc_imm, pc_next, diff_ab;
   logic [XlenW-1:0]     sh_src, jalr_tgt;
   logic [4:0]           shamt;
   logic                 lts_ab, ltu_ab, lts_ai, ltu_ai, eq_ab, cond;

   // handshake: each stage opens when empty or when it drains this cycle
   assign s2_open   = !rsp_valid_ff || rsp_ready;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign s1_fire   = s1_valid_ff && s2_open;
   assign req_ready = s1_open;

   assign s1_valid_in  = s1_open ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_open ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture request payload
   always_ff @(posedge clock) begin
      if (req_valid && s1_open) begin
         op_ff     <= req_opcode;
         a_ff      <= req_operand_a;
         b_ff      <= req_operand_b;
         imm_ff    <= req_immediate;
         pc_ff     <= req_instr_addr;
         pred_ff   <= req_predicted_addr;
         s1_tag_ff <= req_entry_tag;
      end
   end

   // adders and comparators, several shared by more than one opcode
   assign sum_a_imm  = a_ff + imm_ff;
   assign sum_pc_imm = pc_ff + imm_ff;
   assign pc_next    = pc_ff + InstrBytes;
   assign diff_ab    = a_ff - b_ff;
   assign jalr_tgt   = {sum_a_imm[XlenW-1:1], 1'b0};
   assign eq_ab      = (a_ff == b_ff);
   assign lts_ab     = ($signed(a_ff) < $signed(b_ff));
   assign ltu_ab     = (a_ff < b_ff);
   assign lts_ai     = ($signed(a_ff) < $signed(imm_ff));
   assign ltu_ai     = (a_ff < imm_ff);

   // shift amount from immediate for the I-type shifts, from rs2 otherwise
   assign sh_src = (op_ff == OP_SLLI || op_ff == OP_SRLI || op_ff == OP_SRAI) ? imm_ff : b_ff;
   assign shamt  = sh_src[4:0];

   // branch condition
   always_comb begin
      unique case (op_ff)
         OP_BEQ:  cond = eq_ab;
         OP_BNE:  cond = !eq_ab;
         OP_BLT:  cond = lts_ab;
         OP_BGE:  cond = !lts_ab;
         OP_BLTU: cond = ltu_ab;
         OP_BGEU: cond = !ltu_ab;
         default: cond = 1'b0;
      endcase
   end

   // destination value and control resolution
   always_comb begin
      rsp_in = '0;
      unique case (op_ff)
         OP_LUI:   rsp_in.result_value = imm_ff;
         OP_AUIPC: rsp_in.result_value = sum_pc_imm;
         OP_JAL, OP_JALR: rsp_in.result_value = pc_next;
         OP_ADDI:  rsp_in.result_value = sum_a_imm;
         OP_SLTI:  rsp_in.result_value = {{(XlenW-1){1'b0}}, lts_ai};
         OP_SLTIU: rsp_in.result_value = {{(XlenW-1){1'b0}}, ltu_ai};
         OP_XORI:  rsp_in.result_value = a_ff ^ imm_ff;
         OP_ORI:   rsp_in.result_value = a_ff | imm_ff;
         OP_ANDI:  rsp_in.result_value = a_ff & imm_ff;
         OP_SLLI, OP_SLL: rsp_in.result_value = a_ff << shamt;
         OP_SRLI, OP_SRL: rsp_in.result_value = a_ff >> shamt;
         OP_SRAI, OP_SRA: rsp_in.result_value = $unsigned($signed(a_ff) >>> shamt);
         OP_ADD:   rsp_in.result_value = a_ff + b_ff;
         OP_SUB:   rsp_in.result_value = diff_ab;
         OP_SLT:   rsp_in.result_value = {{(XlenW-1){1'b0}}, lts_ab};
         OP_SLTU:  rsp_in.result_value = {{(XlenW-1){1'b0}}, ltu_ab};
         OP_XOR:   rsp_in.result_value = a_ff ^ b_ff;
         OP_OR:    rsp_in.result_value = a_ff | b_ff;
         OP_AND:   rsp_in.result_value = a_ff & b_ff;
         default:  rsp_in.result_value = '0;
      endcase

      unique case (op_ff)
         OP_JAL: begin
            rsp_in.control_op    = 1'b1;
            rsp_in.taken_flag    = 1'b1;
            rsp_in.resolved_addr = sum_pc_imm;
         end
         OP_JALR: begin
            rsp_in.control_op    = 1'b1;
            rsp_in.taken_flag    = 1'b1;
            rsp_in.resolved_addr = jalr_tgt;
         end
         OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
            rsp_in.control_op    = 1'b1;
            rsp_in.taken_flag    = cond;
            rsp_in.resolved_addr = cond ? sum_pc_imm : pc_next;
         end
         default: begin
            rsp_in.control_op    = 1'b0;
            rsp_in.taken_flag    = 1'b0;
            rsp_in.resolved_addr = '0;
         end
      endcase

      rsp_in.mispredicted = rsp_in.control_op && (rsp_in.resolved_addr != pred_ff);
   end

   // capture response payload
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff     <= rsp_in;
         rsp_tag_ff <= s1_tag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_ff.result_value;
   assign rsp_control_op    = rsp_ff.control_op;
   assign rsp_taken_flag    = rsp_ff.taken_flag;
   assign rsp_resolved_addr = rsp_ff.resolved_addr;
   assign rsp_mispredicted  = rsp_ff.mispredicted;
   assign rsp_out_tag       = rsp_tag_ff;

   // checks
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("operand stage advanced but no response held");

   a_noncontrol_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.control_op |->
         !rsp_ff.taken_flag && !rsp_ff.mispredicted && rsp_ff.resolved_addr == '0)
      else $error("control fields set on a non-control response");

   a_not_taken_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.control_op && !rsp_ff.taken_flag |->
         rsp_ff.result_value == '0)
      else $error("not-taken branch carries a destination value");

endmodule
